### design/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, constants and helpers for the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DATA_WIDTH  = 16;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PROD_W      = 2 * DATA_WIDTH;
    localparam int ACC_W       = 36;
    localparam int ELEM_W      = 16;
    localparam int POS_W       = 3;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [1:0] OP_WR_A    = 2'd0;
    localparam logic [1:0] OP_WR_B    = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [POS_W-1:0]        row_index;
        logic [POS_W-1:0]        col_index;
        logic signed [ELEM_W-1:0] element_value;
    } in_word_t;

    typedef struct packed {
        logic [POS_W-1:0]        out_row;
        logic [POS_W-1:0]        out_col;
        logic signed [ACC_W-1:0] product_value;
        logic                    last;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } ctrl_state_t;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic             rd_first;
        logic             rd_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
        logic             res_last;
    } mme_cmd_t;

    typedef struct packed {
        logic out_valid;
    } mme_stat_t;

    // Dimension register clamped into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] dim_sat(input logic [CFG_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        if (int'(v) > MAX_DIM)
            return DIM_W'(MAX_DIM);
        return DIM_W'(v);
    endfunction

endpackage

### design/matrix_multiply_engine_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core
// Fixed-point C = A x B: element loads into two stores, compute runs
// emit C in row-major order.
// ----------------------------------------------------------------------------
// Store write words: one per cycle while no compute run is active, no result.
// Compute word: each C element takes n store reads, one per step (n = inner
//   length), then passes the read, product and result registers; the next
//   element waits for its word to be taken; input stalls until the last is.
// Reset: control and dimension registers (8,8,8) clear asynchronously;
//   store contents are undefined until written.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mme_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mme_pkg::out_word_t            out_data,
    input  logic                          cfg_wr_en,
    input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]     cfg_data
);
    import mme_pkg::*;

    logic [CFG_W-1:0] rows_a_reg, inner_len_reg, cols_b_reg;
    mme_cmd_t         cmd;
    mme_stat_t        stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_W'(8);
            inner_len_reg <= CFG_W'(8);
            cols_b_reg    <= CFG_W'(8);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                CFG_INNER_LEN: inner_len_reg <= cfg_data;
                CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    mme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .rows_a    (rows_a_reg),
        .inner_len (inner_len_reg),
        .cols_b    (cols_b_reg),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mme_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // input is only open once no result word is pending
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input open while a result word is pending");

    a_compute_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.opcode == OP_COMPUTE) |=> in_stall)
        else $error("compute word did not start a run");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last) |=> !in_stall)
        else $error("input not reopened after final word");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.opcode != OP_COMPUTE) |=> !out_valid)
        else $error("store write produced a result word");

endmodule

### design/mme_ctrl.sv
// ----------------------------------------------------------------------------
// mme_ctrl
// Sequencer: store writes, then the i/j/k walk of a compute run.
// ----------------------------------------------------------------------------
module mme_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  mme_pkg::in_word_t          in_data,
    input  logic [mme_pkg::CFG_W-1:0]  rows_a,
    input  logic [mme_pkg::CFG_W-1:0]  inner_len,
    input  logic [mme_pkg::CFG_W-1:0]  cols_b,
    input  logic                       out_stall,
    input  mme_pkg::mme_stat_t         stat,
    output mme_pkg::mme_cmd_t          cmd
);
    import mme_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic [DIM_W-1:0] dim_m, dim_n, dim_p;
    logic             i_end, j_end, k_end, in_range;

    assign dim_m = dim_sat(rows_a);
    assign dim_n = dim_sat(inner_len);
    assign dim_p = dim_sat(cols_b);

    assign i_end = (DIM_W'(i_reg) + DIM_W'(1)) == dim_m;
    assign j_end = (DIM_W'(j_reg) + DIM_W'(1)) == dim_p;
    assign k_end = (DIM_W'(k_reg) + DIM_W'(1)) == dim_n;

    assign in_range = (int'(in_data.row_index) < MAX_DIM)
                   && (int'(in_data.col_index) < MAX_DIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        cmd          = '0;
        cmd.row      = i_reg;
        cmd.col      = j_reg;
        cmd.k        = k_reg;
        cmd.res_last = i_end && j_end;
        in_stall     = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.opcode)
                        OP_WR_A:    cmd.wr_a = in_range;
                        OP_WR_B:    cmd.wr_b = in_range;
                        OP_COMPUTE:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = ST_ISSUE;
                        end
                        default:    ;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (k_reg == '0);
                cmd.rd_last  = k_end;
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                    k_next = k_reg + IDX_W'(1);
            end
            ST_WAIT:
            begin
                // hold i/j until the result word is taken
                if (stat.out_valid && !out_stall)
                begin
                    if (i_end && j_end)
                        state_next = ST_IDLE;
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (j_end)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                            j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

### design/mme_datapath.sv
// ----------------------------------------------------------------------------
// mme_datapath
// A and B stores, multiply-accumulate pipeline and result register.
// ----------------------------------------------------------------------------
module mme_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  mme_pkg::mme_cmd_t  cmd,
    input  mme_pkg::in_word_t  in_data,
    input  logic               out_stall,
    output mme_pkg::mme_stat_t stat,
    output logic               out_valid,
    output mme_pkg::out_word_t out_data
);
    import mme_pkg::*;

    logic [DATA_WIDTH-1:0] a_mem [STORE_DEPTH];
    logic [DATA_WIDTH-1:0] b_mem [STORE_DEPTH];

    logic [ADDR_W-1:0]     wr_addr, rd_addr_a, rd_addr_b;
    logic [DATA_WIDTH-1:0] wr_data;

    logic signed [DATA_WIDTH-1:0] a_rd_reg, b_rd_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [ACC_W-1:0]      acc_reg, acc_next, prod_ext;
    logic                         s1_valid_reg, s1_first_reg, s1_last_reg;
    logic                         s2_valid_reg, s2_first_reg, s2_last_reg;
    logic                         out_valid_reg, out_valid_next;
    out_word_t                    out_data_reg;
    logic                         res_load;

    assign wr_addr   = ADDR_W'(int'(in_data.row_index) * MAX_DIM + int'(in_data.col_index));
    assign rd_addr_a = ADDR_W'(int'(cmd.row) * MAX_DIM + int'(cmd.k));
    assign rd_addr_b = ADDR_W'(int'(cmd.k) * MAX_DIM + int'(cmd.col));
    assign wr_data   = DATA_WIDTH'(signed'(in_data.element_value));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            a_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            a_rd_reg <= signed'(a_mem[rd_addr_a]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b)
            b_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            b_rd_reg <= signed'(b_mem[rd_addr_b]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_first_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd.rd_en;
            s1_first_reg  <= cmd.rd_first;
            s1_last_reg   <= cmd.rd_last;
            s2_valid_reg  <= s1_valid_reg;
            s2_first_reg  <= s1_first_reg;
            s2_last_reg   <= s1_last_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            prod_reg <= a_rd_reg * b_rd_reg;
        if (s2_valid_reg)
            acc_reg <= acc_next;
        if (res_load)
        begin
            out_data_reg.out_row       <= POS_W'(cmd.row);
            out_data_reg.out_col       <= POS_W'(cmd.col);
            out_data_reg.product_value <= acc_next;
            out_data_reg.last          <= cmd.res_last;
        end
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign acc_next = s2_first_reg ? prod_ext : acc_reg + prod_ext;
    // row/col come straight from the sequencer, which holds them until the word is taken
    assign res_load = s2_valid_reg && s2_last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;
    assign stat.out_valid = out_valid_reg;

endmodule

### tb/sv/tb_matrix_multiply_engine_core.sv
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine_core
// Self-checking bench for the fixed-point matrix multiply core. Store writes,
// ignored opcodes and compute words go in over the valid/stall port. A local
// model of both stores and the dimension registers predicts every C element
// in row-major order, and each word taken from the output is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine_core;

    import mme_pkg::*;

    localparam logic [1:0] OP_NOP        = 2'd3;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         PHASE_WORDS   = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // local copy of block state
    logic signed [ELEM_W-1:0] a_mem [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_mem [STORE_DEPTH];
    bit                       a_set [STORE_DEPTH];
    bit                       b_set [STORE_DEPTH];
    logic [CFG_W-1:0]         rows_reg;
    logic [CFG_W-1:0]         inner_reg;
    logic [CFG_W-1:0]         cols_reg;

    out_word_t c_expect_q[$];
    out_word_t c_head;

    int err_count     = 0;
    int cycle_count   = 0;
    int hold_len      = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    matrix_multiply_engine_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timed out", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int clamp_dim(input logic [CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (int'(raw) > MAX_DIM)
            return MAX_DIM;
        return int'(raw);
    endfunction

    function automatic void gemm_apply(input in_word_t w);
        int        addr;
        int        m;
        int        n;
        int        p;
        int        i;
        int        j;
        int        k;
        longint    acc;
        out_word_t r;
        addr = int'(w.row_index) * MAX_DIM + int'(w.col_index);
        case (w.opcode)
            OP_WR_A:
            begin
                a_mem[addr] = w.element_value;
                a_set[addr] = 1'b1;
            end
            OP_WR_B:
            begin
                b_mem[addr] = w.element_value;
                b_set[addr] = 1'b1;
            end
            OP_COMPUTE:
            begin
                m = clamp_dim(rows_reg);
                n = clamp_dim(inner_reg);
                p = clamp_dim(cols_reg);
                for (i = 0; i < m; i++)
                    for (j = 0; j < p; j++)
                    begin
                        acc = 0;
                        for (k = 0; k < n; k++)
                            acc += longint'(a_mem[i * MAX_DIM + k]) *
                                   longint'(b_mem[k * MAX_DIM + j]);
                        r.out_row       = POS_W'(i);
                        r.out_col       = POS_W'(j);
                        r.product_value = ACC_W'(acc);
                        r.last          = (i == m - 1) && (j == p - 1);
                        c_expect_q.push_back(r);
                    end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_field(input string name, input logic signed [63:0] exp_v,
                                input logic signed [63:0] act_v);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (c_expect_q.size() == 0)
            begin
                $display("%0t: unexpected word row %0d col %0d value %0d last %0b",
                         $time, out_data.out_row, out_data.out_col,
                         out_data.product_value, out_data.last);
                err_count++;
            end
            else
            begin
                c_head = c_expect_q.pop_front();
                if (out_data.out_row !== c_head.out_row)
                    report_field("out_row", c_head.out_row, out_data.out_row);
                if (out_data.out_col !== c_head.out_col)
                    report_field("out_col", c_head.out_col, out_data.out_col);
                if (out_data.product_value !== c_head.product_value)
                    report_field("product_value", c_head.product_value,
                                 out_data.product_value);
                if (out_data.last !== c_head.last)
                    report_field("last", c_head.last, out_data.last);
            end
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                hold_left = hold_len;
                hold_len  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers; every task starts and ends on a falling edge
    // ------------------------------------------------------------------------
    function automatic in_word_t mk_word(input logic [1:0] op, input int r, input int c,
                                         input logic signed [ELEM_W-1:0] v);
        in_word_t w;
        w.opcode        = op;
        w.row_index     = POS_W'(r);
        w.col_index     = POS_W'(c);
        w.element_value = v;
        return w;
    endfunction

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // raw register code for a wanted size, sometimes out of range on purpose
    function automatic logic [CFG_W-1:0] dim_code(input int d);
        if (d == 1 && $urandom_range(1) == 1)
            return '0;
        if (d == MAX_DIM && $urandom_range(1) == 1)
            return CFG_W'($urandom_range(15, MAX_DIM + 1));
        return CFG_W'(d);
    endfunction

    function automatic int pick_dim();
        if ($urandom_range(9) == 0)
            return MAX_DIM;
        return $urandom_range(4, 1);
    endfunction

    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        gemm_apply(w);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (c_expect_q.size() != 0)
            @(negedge clk);
        // compute pipeline may still be busy after the last word
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] m_raw, input logic [CFG_W-1:0] n_raw,
                            input logic [CFG_W-1:0] p_raw);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ROWS_A;
        cfg_data  <= m_raw;
        @(negedge clk);
        cfg_index <= CFG_INNER_LEN;
        cfg_data  <= n_raw;
        @(negedge clk);
        cfg_index <= CFG_COLS_B;
        cfg_data  <= p_raw;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        rows_reg  = m_raw;
        inner_reg = n_raw;
        cols_reg  = p_raw;
    endtask

    // writes every entry an m x n by n x p product needs that is still unset,
    // plus a few rewrites, stray writes and the odd ignored opcode, shuffled
    task automatic load_region(input int m, input int n, input int p, output int words);
        in_word_t batch[$];
        in_word_t tmp;
        int       i;
        int       j;
        int       idx;
        for (i = 0; i < m; i++)
            for (j = 0; j < n; j++)
                if (!a_set[i * MAX_DIM + j])
                    batch.push_back(mk_word(OP_WR_A, i, j, rand_elem()));
        for (i = 0; i < n; i++)
            for (j = 0; j < p; j++)
                if (!b_set[i * MAX_DIM + j])
                    batch.push_back(mk_word(OP_WR_B, i, j, rand_elem()));
        repeat ($urandom_range(2))
        begin
            batch.push_back(mk_word(OP_WR_A, $urandom_range(m - 1), $urandom_range(n - 1),
                                    rand_elem()));
            batch.push_back(mk_word(OP_WR_B, $urandom_range(n - 1), $urandom_range(p - 1),
                                    rand_elem()));
        end
        repeat ($urandom_range(3))
            batch.push_back(mk_word($urandom_range(1) ? OP_WR_A : OP_WR_B,
                                    $urandom_range(7), $urandom_range(7), rand_elem()));
        if ($urandom_range(4) == 0)
            batch.push_back(mk_word(OP_NOP, $urandom_range(7), $urandom_range(7),
                                    ELEM_W'($urandom)));
        for (i = batch.size() - 1; i > 0; i--)
        begin
            idx        = $urandom_range(i);
            tmp        = batch[i];
            batch[i]   = batch[idx];
            batch[idx] = tmp;
        end
        words = 0;
        foreach (batch[q])
        begin
            send_word(batch[q]);
            if (batch[q].opcode != OP_NOP)
                words++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_single_element();
        logic signed [ELEM_W-1:0] av [4];
        logic signed [ELEM_W-1:0] bv [4];
        av = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'shffff};
        bv = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0001};
        set_dims(4'd1, 4'd1, 4'd1);
        for (int t = 0; t < 4; t++)
        begin
            send_word(mk_word(OP_WR_A, 0, 0, av[t]));
            send_word(mk_word(OP_WR_B, 0, 0, bv[t]));
            send_word(mk_word(OP_COMPUTE, 0, 0, '0));
        end
    endtask

    // far corner writes, ignored opcode, zero-sized registers clamp to one
    task automatic test_clamp_and_indices();
        send_word(mk_word(OP_WR_A, 7, 7, 16'sh7fff));
        send_word(mk_word(OP_WR_B, 7, 7, 16'sh8000));
        send_word(mk_word(OP_WR_A, 7, 0, 16'sh5a5a));
        send_word(mk_word(OP_WR_B, 0, 7, 16'sha5a5));
        send_word(mk_word(OP_NOP, 7, 7, '1));
        send_word(mk_word(OP_NOP, 0, 0, '0));
        set_dims(4'd0, 4'd0, 4'd0);
        send_word(mk_word(OP_COMPUTE, 7, 7, '1));
    endtask

    // output held off for a long stretch while compute and store words queue up
    task automatic test_pressure();
        int words;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        set_dims(4'd4, 4'd4, 4'd4);
        load_region(4, 4, 4, words);
        hold_len = HOLD_CYCLES;
        send_word(mk_word(OP_COMPUTE, 0, 0, '0));
        send_word(mk_word(OP_COMPUTE, 0, 0, '0));
        send_word(mk_word(OP_WR_A, 1, 2, rand_elem()));
        send_word(mk_word(OP_WR_B, 3, 0, rand_elem()));
        send_word(mk_word(OP_COMPUTE, 0, 0, '0));
    endtask

    task automatic test_random_phase(input int in_pct, input int out_pct, input int target);
        int sent;
        int words;
        int m;
        int n;
        int p;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        sent = 0;
        while (sent < target)
        begin
            m = pick_dim();
            n = pick_dim();
            p = pick_dim();
            set_dims(dim_code(m), dim_code(n), dim_code(p));
            load_region(m, n, p, words);
            sent += words;
            repeat ($urandom_range(2, 1))
            begin
                send_word(mk_word(OP_COMPUTE, $urandom_range(7), $urandom_range(7),
                                  ELEM_W'($urandom)));
                sent++;
            end
        end
    endtask

    // largest sizes with the most negative elements, then one row flipped
    task automatic test_full_size();
        in_idle_pct   = 0;
        out_stall_pct = 20;
        set_dims(4'd15, 4'd9, 4'd8);
        for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++)
            begin
                send_word(mk_word(OP_WR_A, r, c, 16'sh8000));
                send_word(mk_word(OP_WR_B, r, c, 16'sh8000));
            end
        send_word(mk_word(OP_COMPUTE, 0, 0, '0));
        for (int c = 0; c < MAX_DIM; c++)
            send_word(mk_word(OP_WR_A, 0, c, 16'sh7fff));
        send_word(mk_word(OP_COMPUTE, 0, 0, '0));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rows_reg  = CFG_W'(MAX_DIM);
        inner_reg = CFG_W'(MAX_DIM);
        cols_reg  = CFG_W'(MAX_DIM);
        for (int e = 0; e < STORE_DEPTH; e++)
        begin
            a_mem[e] = '0;
            b_mem[e] = '0;
            a_set[e] = 1'b0;
            b_set[e] = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_element();
        test_clamp_and_indices();
        test_pressure();
        test_random_phase(0, 0, PHASE_WORDS);
        test_random_phase(51, 0, PHASE_WORDS);
        test_random_phase(0, 51, PHASE_WORDS);
        test_random_phase(20, 20, PHASE_WORDS);
        test_full_size();

        wait_idle();
        if (err_count == 0 && c_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
design/mme_pkg.sv
design/mme_ctrl.sv
design/mme_datapath.sv
design/matrix_multiply_engine_core.sv
tb/sv/tb_matrix_multiply_engine_core.sv
